@@ rtl/pwe_pkg.sv @@
// ----------------------------------------------------------------------------
// pwe_pkg
// Shared constants, types and elaboration-time tables for the periodic
// waveform evaluator.
// ----------------------------------------------------------------------------
package pwe_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TIME_W          = 40;
  localparam int OUT_W           = 32;
  localparam int MODE_W          = 3;
  localparam int GAIN_W          = 24;
  localparam int OFFSET_W        = 32;

  // 2*pi in q.32, rounded to the working fraction width
  localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;
  localparam longint unsigned TWO_PI_Q =
    (TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam int PI_W = $clog2(TWO_PI_Q + 1);
  localparam logic [PI_W-1:0] TWO_PI = PI_W'(TWO_PI_Q);

  // signed angle width: 64-bit product shifted down, plus phase
  localparam int ANG_W     = 65 - FRAC_BITS;
  localparam int NDIG      = (ANG_W - 1 + 7) / 8;
  localparam int RES_SUM_W = PI_W + 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_SINE     = 3'd0,
    MODE_SQUARE   = 3'd1,
    MODE_TRIANGLE = 3'd2,
    MODE_SAW_UP   = 3'd3,
    MODE_SAW_DOWN = 3'd4
  } wave_mode_t;

  // register index on the configuration port
  typedef enum logic [2:0] {
    REG_WAVE_MODE = 3'd0,
    REG_AMPLITUDE = 3'd1,
    REG_OFFSET    = 3'd2,
    REG_FREQUENCY = 3'd3,
    REG_PHASE     = 3'd4
  } reg_index_t;

  // residue of each byte digit at each digit position, modulo 2*pi
  typedef logic [NDIG-1:0][255:0][PI_W-1:0] res_tab_t;

  function automatic res_tab_t build_res_tab();
    res_tab_t tab;
    longint unsigned pw;
    pw = 1;
    for (int k = 0; k < NDIG; k++) begin
      for (int d = 0; d < 256; d++) begin
        tab[k][d] = PI_W'((longint'(d) * pw) % TWO_PI_Q);
      end
      pw = (pw * 256) % TWO_PI_Q;
    end
    return tab;
  endfunction

  function automatic longint unsigned pow2_mod(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = (r * 2) % TWO_PI_Q;
    end
    return r;
  endfunction

  localparam res_tab_t RES_TAB = build_res_tab();
  // residue of the sign weight -2^(ANG_W-1)
  localparam logic [PI_W-1:0] NEG_RES =
    PI_W'((TWO_PI_Q - pow2_mod(ANG_W - 1)) % TWO_PI_Q);

endpackage

@@ rtl/periodic_waveform_evaluator.sv @@
// ----------------------------------------------------------------------------
// periodic_waveform_evaluator
// Evaluates offset + amplitude * wave(frequency * time + phase) per request.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one unsigned q24.16 time point and
// produces exactly one saturated signed q16.16 value on the master stream.
// The datapath is a 20-stage pipeline: a new request is taken every clock while
// the output side does not stall; the rate is one request per cycle, set by the
// single-issue pipeline, with the per-stage ready chain letting requests fill
// bubbles while a result waits at the output.
// The wave shape is chosen by wave_mode (sine, square, triangle, rising or
// falling sawtooth; unused codes give just the offset). Sine is a quarter-wave
// odd polynomial over 2^SINE_TABLE_BITS phase steps. Registers sit on an APB
// port at byte address 4*index and should only be written while idle.
// ----------------------------------------------------------------------------
module periodic_waveform_evaluator (
  input  logic        clk,
  input  logic        rst,
  // slave stream: tdata = time_point[39:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // master stream: tdata = wave_value[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int F    = pwe_pkg::FRAC_BITS;
  localparam int B    = pwe_pkg::SINE_TABLE_BITS;
  localparam int PW   = pwe_pkg::PI_W;
  localparam int AW   = pwe_pkg::ANG_W;
  localparam int QB   = (F + 2 > B) ? F + 2 : B;   // quotient bits of r / 2*pi
  localparam int QBS  = B - 2;                      // quarter-wave index bits
  localparam int K    = PW + 1;
  localparam int RW   = QB + 3;
  localparam int NS   = 20;
  localparam int WW   = F + 2;
  localparam int GW   = pwe_pkg::GAIN_W;
  localparam int PGW  = GW + WW;
  localparam longint unsigned RECIP_Q =
    ((64'd1 << (QB + K)) + pwe_pkg::TWO_PI_Q - 1) / pwe_pkg::TWO_PI_Q;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_Q);
  localparam logic [GW-1:0] ONE_CFG = GW'(64'd1 << F);
  localparam logic signed [WW-1:0] ONE_W = WW'(64'd1 << F);
  localparam logic [QBS:0] QUARTER = (QBS + 1)'(64'd1 << QBS);

  // sine polynomial coefficients, q.30
  localparam logic signed [32:0] C1 = 33'sd1686629713;
  localparam logic signed [32:0] C3 = 33'sd693598668;
  localparam logic signed [32:0] C5 = 33'sd85569306;
  localparam logic signed [32:0] C7 = 33'sd5026995;
  localparam logic signed [32:0] C9 = 33'sd172272;

  // per-stage payload, each stage fills in its own fields
  typedef struct packed {
    logic [pwe_pkg::TIME_W-1:0] t;
    logic signed [44:0]         plo;
    logic signed [44:0]         phi;
    logic signed [63:0]         prod;
    logic signed [AW-1:0]       ang;
    logic [F-1:0]               fr;
    logic [F-1:0]               saw_up;
    logic [F-1:0]               saw_dn;
    logic [F+PW-1:0]            trim;
    logic signed [AW-1:0]       xs;
    logic [PW-1:0]              rr;
    logic [QB:0]                q0;
    logic [QB-1:0]              vf;
    logic [1:0]                 quad;
    logic signed [32:0]         u;
    logic signed [WW-1:0]       tri_v;
    logic signed [32:0]         u2;
    logic signed [32:0]         acc;
    logic signed [32:0]         s;
    logic signed [WW-1:0]       w;
    logic signed [PGW-1:0]      gprod;
    logic [pwe_pkg::OUT_W-1:0]  res;
  } pipe_t;

  logic [2:0]          wave_mode;
  logic [GW-1:0]       amplitude;
  logic [31:0]         offset;
  logic [GW-1:0]       frequency;
  logic [GW-1:0]       phase;

  pipe_t               pipe      [NS];
  pipe_t               pipe_next [NS];
  logic [NS-1:0]       v;
  logic [NS-1:0]       en;
  logic [PW-1:0]       wrap_r;
  logic                cfg_wr;

  function automatic logic signed [32:0] mul30(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
    logic [32:0] ma;
    logic [32:0] mb;
    logic [65:0] p;
    logic [32:0] q;
    ma = a[32] ? 33'(-a) : 33'(a);
    mb = b[32] ? 33'(-b) : 33'(b);
    p  = 66'(ma) * 66'(mb);
    q  = p[62:30];
    return (a[32] ^ b[32]) ? -signed'(q) : signed'(q);
  endfunction

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode <= '0;
      amplitude <= ONE_CFG;
      offset    <= '0;
      frequency <= ONE_CFG;
      phase     <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        pwe_pkg::REG_WAVE_MODE: wave_mode <= pwdata[2:0];
        pwe_pkg::REG_AMPLITUDE: amplitude <= pwdata[GW-1:0];
        pwe_pkg::REG_OFFSET:    offset    <= pwdata;
        pwe_pkg::REG_FREQUENCY: frequency <= pwdata[GW-1:0];
        pwe_pkg::REG_PHASE:     phase     <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      pwe_pkg::REG_WAVE_MODE: prdata = 32'(wave_mode);
      pwe_pkg::REG_AMPLITUDE: prdata = 32'(amplitude);
      pwe_pkg::REG_OFFSET:    prdata = offset;
      pwe_pkg::REG_FREQUENCY: prdata = 32'(frequency);
      pwe_pkg::REG_PHASE:     prdata = 32'(phase);
      default:                prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NS-1] = !v[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];
  assign m_tdata  = pipe[NS-1].res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) pipe[k] <= pipe_next[k];
    end
  end

  // angle reduction for sine, square and triangle (stages 6 and 7)
  pwe_wrap u_wrap (
    .clk (clk),
    .en  (en[7:6]),
    .x   (pipe[5].xs),
    .r   (wrap_r)
  );

  // ---------------- datapath ----------------
  always_comb begin
    logic signed [63:0]    ftl;
    logic [PW+RW-1:0]      rp;
    logic [QB+PW:0]        chk;
    logic [QB+PW:0]        lhs;
    logic [B-1:0]          idx;
    logic [QBS:0]          xq;
    logic [QBS:0]          xm;
    logic signed [WW:0]    tv;
    logic signed [WW:0]    tr;
    logic signed [32:0]    sc;
    logic [F:0]            rnd;
    logic signed [WW-1:0]  sr;
    logic signed [33:0]    sum;

    pipe_next[0]   = pipe[0];
    pipe_next[0].t = s_tdata;
    for (int k = 1; k < NS; k++) begin
      pipe_next[k] = pipe[k-1];
    end

    // time times frequency, cut into two 20-bit halves of time
    pipe_next[1].plo = signed'(frequency) * signed'({1'b0, pipe[0].t[19:0]});
    pipe_next[1].phi = signed'(frequency) * signed'({1'b0, pipe[0].t[39:20]});

    pipe_next[2].prod = (64'(pipe[1].phi) <<< 20) + 64'(pipe[1].plo);

    // floor shift to q.F, add phase
    ftl = pipe[2].prod >>> F;
    pipe_next[3].ang = AW'(ftl) + AW'(signed'(phase));
    pipe_next[3].fr  = pipe[2].prod[2*F-1:F];

    pipe_next[4].trim   = (F + PW)'(pipe[3].fr) * (F + PW)'(pwe_pkg::TWO_PI);
    pipe_next[4].saw_up = pipe[3].ang[F-1:0];
    pipe_next[4].saw_dn = F'(-pipe[3].ang);

    // triangle wraps frac(ft) * 2*pi + phase, the others wrap the angle
    if (wave_mode == pwe_pkg::MODE_TRIANGLE) begin
      pipe_next[5].xs = AW'(signed'(phase)) +
                        AW'(signed'({1'b0, pipe[4].trim[F+PW-1:F]}));
    end else begin
      pipe_next[5].xs = pipe[4].ang;
    end

    // quotient estimate of r * 2^QB / 2*pi by reciprocal
    rp = (PW + RW)'(wrap_r) * (PW + RW)'(RECIP);
    pipe_next[8].rr = wrap_r;
    pipe_next[8].q0 = rp[K +: QB + 1];

    // estimate is exact or one high
    chk = (QB + PW + 1)'(pipe[8].q0) * (QB + PW + 1)'(pwe_pkg::TWO_PI);
    lhs = (QB + PW + 1)'({pipe[8].rr, {QB{1'b0}}});
    pipe_next[9].vf = (chk > lhs) ? QB'(pipe[8].q0 - 1'b1) : QB'(pipe[8].q0);

    // quadrant, mirrored quarter position, triangle value
    idx = pipe[9].vf[QB-1 -: B];
    pipe_next[10].quad = idx[B-1:B-2];
    xq = (QBS + 1)'(idx[QBS-1:0]);
    xm = idx[B-2] ? QUARTER - xq : xq;
    pipe_next[10].u = 33'(xm) << (30 - QBS);
    tv = (WW + 1)'(pipe[9].vf[QB-1 -: WW]);
    if (tv < (WW + 1)'(ONE_W)) begin
      tr = tv;
    end else if (tv < 3 * (WW + 1)'(ONE_W)) begin
      tr = 2 * (WW + 1)'(ONE_W) - tv;
    end else begin
      tr = tv - 4 * (WW + 1)'(ONE_W);
    end
    pipe_next[10].tri_v = WW'(tr);

    // odd polynomial, one product per stage
    pipe_next[11].u2  = mul30(pipe[10].u, pipe[10].u);
    pipe_next[12].acc = mul30(C9, pipe[11].u2) - C7;
    pipe_next[13].acc = mul30(pipe[12].acc, pipe[12].u2) + C5;
    pipe_next[14].acc = mul30(pipe[13].acc, pipe[13].u2) - C3;
    pipe_next[15].acc = mul30(pipe[14].acc, pipe[14].u2) + C1;
    pipe_next[16].s   = mul30(pipe[15].acc, pipe[15].u);

    // clamp, round to q.F, sign by quadrant, then select the wave
    if (pipe[16].s < 0) begin
      sc = '0;
    end else if (pipe[16].s > (33'sd1 <<< 30)) begin
      sc = 33'sd1 <<< 30;
    end else begin
      sc = pipe[16].s;
    end
    rnd = (F + 1)'((sc + (33'sd1 <<< (29 - F))) >>> (30 - F));
    sr  = pipe[16].quad[1] ? -WW'(rnd) : WW'(rnd);
    unique case (wave_mode)
      pwe_pkg::MODE_SINE:     pipe_next[17].w = sr;
      pwe_pkg::MODE_SQUARE: begin
        if (sr == '0) pipe_next[17].w = '0;
        else pipe_next[17].w = pipe[16].quad[1] ? -ONE_W : ONE_W;
      end
      pwe_pkg::MODE_TRIANGLE: pipe_next[17].w = pipe[16].tri_v;
      pwe_pkg::MODE_SAW_UP:   pipe_next[17].w = WW'(pipe[16].saw_up);
      pwe_pkg::MODE_SAW_DOWN: pipe_next[17].w = WW'(pipe[16].saw_dn);
      default:                pipe_next[17].w = '0;
    endcase

    pipe_next[18].gprod = PGW'(signed'(amplitude)) * PGW'(pipe[17].w);

    // offset add with saturation to 32 bits
    sum = 34'(signed'(offset)) + 34'(pipe[18].gprod >>> F);
    if (sum > 34'sd2147483647) begin
      pipe_next[19].res = 32'h7fff_ffff;
    end else if (sum < -34'sd2147483648) begin
      pipe_next[19].res = 32'h8000_0000;
    end else begin
      pipe_next[19].res = sum[31:0];
    end
  end

  // ---------------- assertions ----------------
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !v[NS-1] |-> s_tready)
    else $error("input not ready with empty output stage");

  a_wrap_in_range: assert property (@(posedge clk) disable iff (rst)
    v[7] |-> (wrap_r < pwe_pkg::TWO_PI))
    else $error("reduced angle not below 2*pi");

  a_quotient_floor: assert property (@(posedge clk) disable iff (rst)
    v[9] |-> ((QB + PW + 1)'(pipe[9].vf) * (QB + PW + 1)'(pwe_pkg::TWO_PI) <=
              (QB + PW + 1)'({pipe[9].rr, {QB{1'b0}}})))
    else $error("phase quotient too large");

  a_square_levels: assert property (@(posedge clk) disable iff (rst)
    (v[17] && wave_mode == pwe_pkg::MODE_SQUARE) |->
      (pipe[17].w == ONE_W || pipe[17].w == -ONE_W || pipe[17].w == '0))
    else $error("square wave level out of set");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

@@ rtl/pwe_wrap.sv @@
// ----------------------------------------------------------------------------
// pwe_wrap
// Two-stage reduction of a signed angle into [0, 2*pi) by digit residues.
// ----------------------------------------------------------------------------
module pwe_wrap (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic signed [pwe_pkg::ANG_W-1:0]  x,
  output logic [pwe_pkg::PI_W-1:0]          r
);

  localparam int MAG_W = pwe_pkg::NDIG * 8;
  localparam int SW    = pwe_pkg::RES_SUM_W;

  logic [MAG_W-1:0] mag;
  logic [SW-1:0]    sum;
  logic [SW-1:0]    sum_q;
  logic [SW-1:0]    red;

  assign mag = MAG_W'(x[pwe_pkg::ANG_W-2:0]);

  // sum of digit residues, sign weight folded in
  always_comb begin
    sum = x[pwe_pkg::ANG_W-1] ? SW'(pwe_pkg::NEG_RES) : '0;
    for (int k = 0; k < pwe_pkg::NDIG; k++) begin
      sum = sum + SW'(pwe_pkg::RES_TAB[k][mag[8*k +: 8]]);
    end
  end

  // sum stays below 8 * 2*pi: three conditional subtracts
  always_comb begin
    red = sum_q;
    if (red >= (SW'(pwe_pkg::TWO_PI) << 2)) red = red - (SW'(pwe_pkg::TWO_PI) << 2);
    if (red >= (SW'(pwe_pkg::TWO_PI) << 1)) red = red - (SW'(pwe_pkg::TWO_PI) << 1);
    if (red >= SW'(pwe_pkg::TWO_PI)) red = red - SW'(pwe_pkg::TWO_PI);
  end

  always_ff @(posedge clk) begin
    if (en[0]) sum_q <= sum;
    if (en[1]) r <= pwe_pkg::PI_W'(red);
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic waveform evaluator: time points are
// streamed in under random idling and back-pressure, every result is checked
// in order against a fixed-point model of the wave math held in a small
// scoreboard, and the registers are swept through several settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = pwe_pkg::FRAC_BITS;
  localparam int TIME_W    = pwe_pkg::TIME_W;
  localparam int OUT_W     = pwe_pkg::OUT_W;
  localparam int MODE_W    = pwe_pkg::MODE_W;
  localparam int GAIN_W    = pwe_pkg::GAIN_W;
  localparam int OFFSET_W  = pwe_pkg::OFFSET_W;

  localparam longint ONE_Q = 64'sd1 << FRAC_BITS;
  localparam longint FMASK = ONE_Q - 1;
  localparam longint TWOPI = longint'(pwe_pkg::TWO_PI_Q);

  // quarter-wave sine polynomial coefficients, q.30
  localparam longint K1 = 1686629713;
  localparam longint K3 = 693598668;
  localparam longint K5 = 85569306;
  localparam longint K7 = 5026995;
  localparam longint K9 = 172272;

  // expected wave values in request order, plus the register copy
  class wave_scoreboard;
    logic [MODE_W-1:0]          mode;
    logic signed [GAIN_W-1:0]   amp;
    logic signed [OFFSET_W-1:0] offs;
    logic signed [GAIN_W-1:0]   freq;
    logic signed [GAIN_W-1:0]   phs;
    logic [OUT_W-1:0]           wave_due[$];
    int                         errors;

    function void clear_regs();
      mode = pwe_pkg::MODE_SINE;
      amp  = GAIN_W'(ONE_Q);
      offs = '0;
      freq = GAIN_W'(ONE_Q);
      phs  = '0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      case (idx)
        pwe_pkg::REG_WAVE_MODE: mode = val[MODE_W-1:0];
        pwe_pkg::REG_AMPLITUDE: amp  = val[GAIN_W-1:0];
        pwe_pkg::REG_OFFSET:    offs = val;
        pwe_pkg::REG_FREQUENCY: freq = val[GAIN_W-1:0];
        pwe_pkg::REG_PHASE:     phs  = val[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint turn_mod(longint a);
      longint r;
      r = a % TWOPI;
      if (r < 0) r += TWOPI;
      return r;
    endfunction

    // q.30 product truncated toward zero
    function longint q30_mul(longint a, longint b);
      longint ua, ub, p;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = (ua * ub) >>> 30;
      return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function longint sine_of(longint angle);
      longint r, idx, quad, x, u, u2, acc, s;
      int qb;
      qb = pwe_pkg::SINE_TABLE_BITS - 2;
      r = turn_mod(angle);
      idx = (r << pwe_pkg::SINE_TABLE_BITS) / TWOPI;
      quad = (idx >> qb) & 3;
      x = idx & ((64'sd1 << qb) - 1);
      if (quad[0]) x = (64'sd1 << qb) - x;
      u = x << (30 - qb);
      u2 = q30_mul(u, u);
      acc = K9;
      acc = q30_mul(acc, u2) - K7;
      acc = q30_mul(acc, u2) + K5;
      acc = q30_mul(acc, u2) - K3;
      acc = q30_mul(acc, u2) + K1;
      s = q30_mul(acc, u);
      if (s < 0) s = 0;
      if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
      s = (s + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      return quad[1] ? -s : s;
    endfunction

    function longint triangle_of(longint ft, longint ph);
      longint r, v;
      r = turn_mod((((ft & FMASK) * TWOPI) >>> FRAC_BITS) + ph);
      v = (r << (FRAC_BITS + 2)) / TWOPI;
      if (v < ONE_Q) return v;
      if (v < 3 * ONE_Q) return 2 * ONE_Q - v;
      return v - 4 * ONE_Q;
    endfunction

    function void note_time(logic [TIME_W-1:0] tp);
      longint ft, angle, w, s, res;
      ft = (longint'(freq) * longint'({24'd0, tp})) >>> FRAC_BITS;
      angle = ft + longint'(phs);
      case (mode)
        pwe_pkg::MODE_SINE:   w = sine_of(angle);
        pwe_pkg::MODE_SQUARE: begin
          s = sine_of(angle);
          w = (s > 0) ? ONE_Q : ((s < 0) ? -ONE_Q : 0);
        end
        pwe_pkg::MODE_TRIANGLE: w = triangle_of(ft, longint'(phs));
        pwe_pkg::MODE_SAW_UP:   w = angle & FMASK;
        pwe_pkg::MODE_SAW_DOWN: w = (-angle) & FMASK;
        default:                w = 0; // unused codes leave only the offset
      endcase
      res = longint'(offs) + ((longint'(amp) * w) >>> FRAC_BITS);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      wave_due.push_back(res[OUT_W-1:0]);
    endfunction

    function void check_wave(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (wave_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = wave_due.pop_front();
      if (got !== want) begin
        $display("%0t: wave_value mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [TIME_W-1:0] s_tdata;   // time_point[39:0]
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;   // wave_value[31:0]
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  wave_scoreboard sb;
  bit             calm;        // no idling on either side while set
  int             hold_asks;   // bumped to ask the receiver for a long hold-off
  int             hold_seen;
  int             hold_left;

  periodic_waveform_evaluator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the handshakes hang
  initial begin
    #1ms;
    $display("tb_top NOT OK");
    $finish;
  end

  // request and result monitors, sampling the values from before the edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_time(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_wave(m_tdata);
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // apb write: setup cycle then access cycle
  task automatic reg_write(int idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 5'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_time(logic [TIME_W-1:0] tp);
    if (!calm && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= tp;
    do @(posedge clk); while (!s_tready);
  endtask

  // sender pauses until every result is back, then lets the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.wave_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    logic [TIME_W-1:0] tp;
    tp = TIME_W'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: tp = tp >> $urandom_range(0, 39);
      1: tp = tp & 40'hFFFFF;
      default: ;
    endcase
    return tp;
  endfunction

  // signed register value: extremes, small values or anything
  function automatic logic [31:0] rand_gain(int w);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'(1) << (w - 1);                // most negative
      1: v = (32'(1) << (w - 1)) - 1;          // most positive
      2: v = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: v = $urandom;
    endcase
    if (w < 32) v = v & ((32'(1) << w) - 1);
    return v;
  endfunction

  initial begin
    sb = new();
    sb.clear_regs();
    calm      = 1'b0;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every mode code, unused ones too, at zero, full and odd times
    for (int m = 0; m < 8; m++) begin
      reg_write(pwe_pkg::REG_WAVE_MODE, 32'(m));
      send_time('0);
      send_time('1);
      send_time(40'h55_5555_5555 ^ {40{m[0]}});
      drain();
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < 16; ph++) begin
      reg_write(pwe_pkg::REG_WAVE_MODE,
                ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                            : $urandom_range(0, 4));
      reg_write(pwe_pkg::REG_AMPLITUDE, rand_gain(GAIN_W));
      reg_write(pwe_pkg::REG_OFFSET, rand_gain(OFFSET_W));
      reg_write(pwe_pkg::REG_FREQUENCY, rand_gain(GAIN_W));
      reg_write(pwe_pkg::REG_PHASE, rand_gain(GAIN_W));
      calm = (ph == 5);                 // one long stretch with no idling
      if (ph == 9) hold_asks++;         // fill the pipe and stall the input
      for (int i = 0; i < 102; i++) send_time(rand_time());
      drain();
      calm = 1'b0;
    end

    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
